// ----- design/spfr_pkg.sv -----
// Shared types and constants of the serial packet frame receiver.
`default_nettype none

package spfr_pkg;

  // Configuration register indexes.
  localparam logic CFG_MAX_LENGTH = 1'b0;
  localparam logic CFG_TIMEOUT    = 1'b1;

  // Input operations.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result kinds.
  localparam logic KIND_RESPONSE = 1'b0;
  localparam logic KIND_PAYLOAD  = 1'b1;

  // Error flag bits.
  localparam logic [2:0] ERR_NONE     = 3'b000;
  localparam logic [2:0] ERR_TIMEOUT  = 3'b001;
  localparam logic [2:0] ERR_LENGTH   = 3'b010;
  localparam logic [2:0] ERR_CHECKSUM = 3'b100;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] RESP_ID   = 8'h01;

  // Positions of the five response items.
  localparam logic [2:0] RESP_SYNC_A = 3'd0;
  localparam logic [2:0] RESP_SYNC_B = 3'd1;
  localparam logic [2:0] RESP_IDENT  = 3'd2;
  localparam logic [2:0] RESP_FLAGS  = 3'd3;
  localparam logic [2:0] RESP_CHECK  = 3'd4;

  localparam logic [5:0]  MAX_LENGTH_RESET = 6'd32;
  localparam logic [15:0] TIMEOUT_RESET    = 16'd1000;
  localparam logic [15:0] TICKS_MAX        = 16'hFFFF;

  typedef enum logic [3:0] {
    ST_SYNC1,
    ST_SYNC2,
    ST_LEN,
    ST_DATA,
    ST_SUM,
    ST_FETCH,
    ST_PAYLOAD,
    ST_RESP
  } st_t;

  typedef struct packed {
    logic       take_len;
    logic       take_data;
    logic       clr_err;
    logic [2:0] set_err;
    logic       fetch;
    logic       emit_pay;
    logic       resp_start;
    logic       emit_resp;
  } cmd_t;

  typedef struct packed {
    logic is_sync;
    logic len_over;
    logic len_zero;
    logic data_done;
    logic sum_ok;
    logic tmo_hit;
    logic out_free;
    logic pay_done;
    logic resp_done;
  } sts_t;

endpackage

`default_nettype wire

// ----- design/serial_packet_frame_receiver.sv -----
// Input: a byte or tick item is taken while in_tready is high, which is while a packet is received.
// A completed packet gives a burst: a fetch state reads the payload buffer, then one payload
// item per cycle and five response items follow, paced by out_tready; input waits during the burst.
// Reset: synchronous active-low rst_n clears the state machine, error flags, counters and sets
// max_length to 32 and timeout_ticks to 1000; the payload buffer is not cleared.
`default_nettype none

module serial_packet_frame_receiver #(
  parameter int BUFFER_DEPTH = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire         in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tuser,  // [0] kind
  output logic        out_tlast,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire         cfg_index,
  input  wire  [15:0] cfg_data
);

  spfr_pkg::cmd_t cmd;
  spfr_pkg::sts_t sts;
  logic           in_fire;
  logic           cfg_fire;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_fire  = cfg_valid && cfg_ready;

  spfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .op       (in_tuser),
    .sts      (sts),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  spfr_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .op        (in_tuser),
    .rx_byte   (in_tdata),
    .cfg_fire  (cfg_fire),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

`default_nettype wire

// ----- design/spfr_ctrl.sv -----
// Controller state machine: packet phases and result burst sequencing.
`default_nettype none

module spfr_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_fire,
  input  wire              op,
  input  spfr_pkg::sts_t   sts,
  output logic             in_ready,
  output spfr_pkg::cmd_t   cmd
);

  spfr_pkg::st_t state_r, state_nxt;
  logic          rx_phase;
  logic          tmo_phase;

  assign rx_phase  = (state_r == spfr_pkg::ST_SYNC1) || (state_r == spfr_pkg::ST_SYNC2) ||
                     (state_r == spfr_pkg::ST_LEN)   || (state_r == spfr_pkg::ST_DATA)  ||
                     (state_r == spfr_pkg::ST_SUM);
  assign tmo_phase = (state_r == spfr_pkg::ST_LEN) || (state_r == spfr_pkg::ST_DATA) ||
                     (state_r == spfr_pkg::ST_SUM);
  assign in_ready  = rx_phase;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spfr_pkg::ST_SYNC1;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (in_fire && op == spfr_pkg::OP_TICK) begin
      if (tmo_phase && sts.tmo_hit) begin
        state_nxt = spfr_pkg::ST_RESP;
      end
    end else begin
      unique case (state_r)
        spfr_pkg::ST_SYNC1: begin
          if (in_fire && sts.is_sync) state_nxt = spfr_pkg::ST_SYNC2;
        end
        spfr_pkg::ST_SYNC2: begin
          if (in_fire) state_nxt = sts.is_sync ? spfr_pkg::ST_LEN : spfr_pkg::ST_SYNC1;
        end
        spfr_pkg::ST_LEN: begin
          if (in_fire) begin
            state_nxt = (sts.len_over || sts.len_zero) ? spfr_pkg::ST_RESP
                                                       : spfr_pkg::ST_DATA;
          end
        end
        spfr_pkg::ST_DATA: begin
          if (in_fire && sts.data_done) state_nxt = spfr_pkg::ST_SUM;
        end
        spfr_pkg::ST_SUM: begin
          if (in_fire) state_nxt = sts.sum_ok ? spfr_pkg::ST_FETCH : spfr_pkg::ST_RESP;
        end
        spfr_pkg::ST_FETCH: begin
          state_nxt = spfr_pkg::ST_PAYLOAD;
        end
        spfr_pkg::ST_PAYLOAD: begin
          if (sts.out_free && sts.pay_done) state_nxt = spfr_pkg::ST_RESP;
        end
        spfr_pkg::ST_RESP: begin
          if (sts.out_free && sts.resp_done) state_nxt = spfr_pkg::ST_SYNC1;
        end
        default: state_nxt = spfr_pkg::ST_SYNC1;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    if (in_fire && op == spfr_pkg::OP_TICK) begin
      if (tmo_phase && sts.tmo_hit) begin
        cmd.set_err    = spfr_pkg::ERR_TIMEOUT;
        cmd.resp_start = 1'b1;
      end
    end else begin
      unique case (state_r)
        spfr_pkg::ST_SYNC2: begin
          if (in_fire && sts.is_sync) cmd.clr_err = 1'b1;
        end
        spfr_pkg::ST_LEN: begin
          if (in_fire) begin
            cmd.take_len = 1'b1;
            if (sts.len_over) begin
              cmd.set_err    = spfr_pkg::ERR_LENGTH;
              cmd.resp_start = 1'b1;
            end else if (sts.len_zero) begin
              cmd.resp_start = 1'b1;
            end
          end
        end
        spfr_pkg::ST_DATA: begin
          if (in_fire) cmd.take_data = 1'b1;
        end
        spfr_pkg::ST_SUM: begin
          if (in_fire) begin
            if (sts.sum_ok) begin
              cmd.fetch = 1'b1;
            end else begin
              cmd.set_err    = spfr_pkg::ERR_CHECKSUM;
              cmd.resp_start = 1'b1;
            end
          end
        end
        spfr_pkg::ST_PAYLOAD: begin
          if (sts.out_free) begin
            cmd.emit_pay   = 1'b1;
            cmd.resp_start = sts.pay_done;
          end
        end
        spfr_pkg::ST_RESP: begin
          if (sts.out_free) cmd.emit_resp = 1'b1;
        end
        default: cmd = '0;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/spfr_dp.sv -----
// Datapath: config registers, payload buffer, checksum, tick counter, result register.
`default_nettype none

module spfr_dp #(
  parameter int BUFFER_DEPTH = 32
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_fire,
  input  wire             op,
  input  wire  [7:0]      rx_byte,
  input  wire             cfg_fire,
  input  wire             cfg_idx,
  input  wire  [15:0]     cfg_wdata,
  input  spfr_pkg::cmd_t  cmd,
  output spfr_pkg::sts_t  sts,
  output logic            out_valid,
  input  wire             out_ready,
  output logic            out_kind,
  output logic [7:0]      out_data,
  output logic            out_last
);

  localparam int         AW    = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [5:0] DEPTH = 6'(BUFFER_DEPTH);

  logic [5:0]  max_len_r;
  logic [15:0] tmo_r;
  logic [2:0]  err_r;
  logic [5:0]  len_r;
  logic [5:0]  cnt_r;
  logic [7:0]  sum_r;
  logic [15:0] idle_r, idle_nxt;
  logic [5:0]  idx_r;
  logic [2:0]  ridx_r;
  logic [7:0]  mem [BUFFER_DEPTH];
  logic [7:0]  rd_data_r;
  logic [AW-1:0] raddr_r, raddr_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r;
  logic [7:0]  out_data_r;
  logic        out_last_r;

  logic [5:0]  limit;
  logic [6:0]  cnt_inc;
  logic [6:0]  idx_inc;
  logic [7:0]  resp_byte;
  logic        out_free;

  assign limit    = (max_len_r > DEPTH) ? DEPTH : max_len_r;
  assign cnt_inc  = {1'b0, cnt_r} + 7'd1;
  assign idx_inc  = {1'b0, idx_r} + 7'd1;
  assign out_free = !out_valid_r || out_ready;
  assign idle_nxt = (idle_r == spfr_pkg::TICKS_MAX) ? idle_r : idle_r + 16'd1;

  always_comb begin
    sts.is_sync   = (rx_byte == spfr_pkg::SYNC_BYTE);
    sts.len_over  = (rx_byte > {2'b00, limit});
    sts.len_zero  = (rx_byte == 8'd0);
    sts.data_done = (cnt_inc >= {1'b0, len_r});
    sts.sum_ok    = (rx_byte == ~sum_r);
    sts.tmo_hit   = (idle_nxt > tmo_r);
    sts.out_free  = out_free;
    sts.pay_done  = (idx_inc >= {1'b0, len_r});
    sts.resp_done = (ridx_r == spfr_pkg::RESP_CHECK);
  end

  // Control and configuration state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r   <= spfr_pkg::MAX_LENGTH_RESET;
      tmo_r       <= spfr_pkg::TIMEOUT_RESET;
      err_r       <= spfr_pkg::ERR_NONE;
      len_r       <= '0;
      cnt_r       <= '0;
      idle_r      <= '0;
      idx_r       <= '0;
      ridx_r      <= '0;
      raddr_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_idx)
          spfr_pkg::CFG_MAX_LENGTH: max_len_r <= cfg_wdata[5:0];
          spfr_pkg::CFG_TIMEOUT:    tmo_r     <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_fire) begin
        idle_r <= (op == spfr_pkg::OP_TICK) ? idle_nxt : 16'd0;
      end
      if (cmd.clr_err) begin
        err_r <= spfr_pkg::ERR_NONE;
      end else begin
        err_r <= err_r | cmd.set_err;
      end
      if (cmd.take_len) begin
        len_r <= rx_byte[5:0];
        cnt_r <= '0;
      end else if (cmd.take_data) begin
        cnt_r <= cnt_inc[5:0];
      end
      if (cmd.fetch) begin
        idx_r <= '0;
      end else if (cmd.emit_pay) begin
        idx_r <= idx_inc[5:0];
      end
      if (cmd.resp_start) begin
        ridx_r <= spfr_pkg::RESP_SYNC_A;
      end else if (cmd.emit_resp) begin
        ridx_r <= ridx_r + 3'd1;
      end
      raddr_r     <= raddr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Running checksum over the length byte and the payload.
  always_ff @(posedge clk) begin
    if (cmd.take_len) begin
      sum_r <= rx_byte;
    end else if (cmd.take_data) begin
      sum_r <= sum_r + rx_byte;
    end
  end

  // Payload buffer: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.take_data && cnt_r < DEPTH) begin
      mem[cnt_r[AW-1:0]] <= rx_byte;
    end
    rd_data_r <= mem[raddr_nxt];
  end

  // The read address runs one entry ahead of the item being emitted.
  always_comb begin
    raddr_nxt = raddr_r;
    if (cmd.fetch) begin
      raddr_nxt = '0;
    end else if (cmd.emit_pay && idx_inc < {1'b0, len_r}) begin
      raddr_nxt = idx_inc[AW-1:0];
    end
  end

  always_comb begin
    unique case (ridx_r)
      spfr_pkg::RESP_SYNC_A: resp_byte = spfr_pkg::SYNC_BYTE;
      spfr_pkg::RESP_SYNC_B: resp_byte = spfr_pkg::SYNC_BYTE;
      spfr_pkg::RESP_IDENT:  resp_byte = spfr_pkg::RESP_ID;
      spfr_pkg::RESP_FLAGS:  resp_byte = {5'b00000, err_r};
      spfr_pkg::RESP_CHECK:  resp_byte = ~(8'd1 + {5'b00000, err_r});
      default:               resp_byte = spfr_pkg::SYNC_BYTE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit_pay || cmd.emit_resp) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_pay) begin
      out_kind_r <= spfr_pkg::KIND_PAYLOAD;
      out_data_r <= rd_data_r;
      out_last_r <= 1'b0;
    end else if (cmd.emit_resp) begin
      out_kind_r <= spfr_pkg::KIND_RESPONSE;
      out_data_r <= resp_byte;
      out_last_r <= (ridx_r == spfr_pkg::RESP_CHECK);
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Stream testbench for the serial packet frame receiver, checked against a deframing predictor.
module testbench;
  import spfr_pkg::*;

  localparam int DEPTH         = 32;
  localparam int SETTLE_CYCLES = DEPTH + 16;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int PRINT_CAP     = 40;

  typedef struct packed {
    logic       op;
    logic [7:0] rx;
  } rx_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] val;
    logic       last;
  } frame_byte_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tuser   = OP_BYTE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic        cfg_index  = CFG_MAX_LENGTH;
  logic [15:0] cfg_data   = 16'h0000;

  // Predictor copy of the registers and the receive state.
  logic [5:0]  max_len_reg = 6'd32;
  logic [15:0] tmo_reg     = TIMEOUT_RESET;
  st_t         hunt_phase  = ST_SYNC1;
  logic [2:0]  err_flags   = ERR_NONE;
  logic [7:0]  pay_len     = 8'h00;
  logic [5:0]  pay_taken   = 6'd0;
  logic [7:0]  pay_store [DEPTH];
  logic [15:0] idle_ticks  = 16'h0000;

  frame_byte_t frame_bytes_due [$];
  rx_item_t    rx_feed [$];
  rx_item_t    rx_now;

  int rx_sent    = 0;
  int rx_taken   = 0;
  int mismatches = 0;
  int clk_count  = 0;
  int gap_left   = 0;
  int stall_left = 0;
  bit sender_gaps = 1'b0;
  bit sink_stalls = 1'b0;

  serial_packet_frame_receiver #(.BUFFER_DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    if (mismatches < PRINT_CAP) begin
      $display("mismatch at cycle %0d: %s got %0h want %0h", clk_count, what, got, want);
    end
    mismatches++;
  endtask

  // Every reply is FF FF 01 flags ~(1 + flags), and it sends the receiver back to the hunt.
  task automatic queue_reply();
    logic [7:0] flags;
    logic [7:0] tail;
    flags = {5'b00000, err_flags};
    tail  = RESP_ID + flags;
    tail  = ~tail;
    frame_bytes_due.push_back('{KIND_RESPONSE, SYNC_BYTE, 1'b0});
    frame_bytes_due.push_back('{KIND_RESPONSE, SYNC_BYTE, 1'b0});
    frame_bytes_due.push_back('{KIND_RESPONSE, RESP_ID, 1'b0});
    frame_bytes_due.push_back('{KIND_RESPONSE, flags, 1'b0});
    frame_bytes_due.push_back('{KIND_RESPONSE, tail, 1'b1});
    hunt_phase = ST_SYNC1;
  endtask

  task automatic deframe_step(input logic op, input logic [7:0] b);
    logic [5:0] limit;
    logic [7:0] sum;
    if (op == OP_TICK) begin
      if (idle_ticks != TICKS_MAX) idle_ticks = idle_ticks + 16'd1;
      if ((hunt_phase == ST_LEN || hunt_phase == ST_DATA || hunt_phase == ST_SUM) &&
          idle_ticks > tmo_reg) begin
        err_flags = err_flags | ERR_TIMEOUT;
        queue_reply();
      end
    end else begin
      idle_ticks = 16'h0000;
      case (hunt_phase)
        ST_SYNC2: begin
          if (b == SYNC_BYTE) begin
            hunt_phase = ST_LEN;
            err_flags  = ERR_NONE;
          end else begin
            hunt_phase = ST_SYNC1;
          end
        end
        ST_LEN: begin
          limit     = (max_len_reg > DEPTH) ? 6'(DEPTH) : max_len_reg;
          pay_len   = b;
          pay_taken = 6'd0;
          if (b > {2'b00, limit}) begin
            err_flags = err_flags | ERR_LENGTH;
            queue_reply();
          end else if (b == 8'h00) begin
            queue_reply();
          end else begin
            hunt_phase = ST_DATA;
          end
        end
        ST_DATA: begin
          if (pay_taken < DEPTH) pay_store[pay_taken] = b;
          pay_taken = pay_taken + 6'd1;
          if ({2'b00, pay_taken} >= pay_len) hunt_phase = ST_SUM;
        end
        ST_SUM: begin
          sum = pay_len;
          for (int i = 0; i < pay_len && i < DEPTH; i++) sum = sum + pay_store[i];
          sum = ~sum;
          if (b != sum) begin
            err_flags = err_flags | ERR_CHECKSUM;
          end else begin
            for (int i = 0; i < pay_len && i < DEPTH; i++) begin
              frame_bytes_due.push_back('{KIND_PAYLOAD, pay_store[i], 1'b0});
            end
          end
          queue_reply();
        end
        default: begin
          hunt_phase = (b == SYNC_BYTE) ? ST_SYNC2 : ST_SYNC1;
        end
      endcase
    end
  endtask

  // Sender: one item in flight, held until taken, with optional bursts of idle cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        deframe_step(rx_now.op, rx_now.rx);
        rx_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (rx_feed.size() != 0) begin
          if (sender_gaps && $urandom_range(0, 4) == 0) begin
            gap_left = $urandom_range(1, 12) - 1;
            in_tvalid <= 1'b0;
          end else begin
            rx_now = rx_feed.pop_front();
            in_tuser  <= rx_now.op;
            in_tdata  <= rx_now.rx;
            in_tvalid <= 1'b1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver side: checks each taken item against the oldest one due.
  always @(posedge clk) begin
    frame_byte_t want;
    clk_count++;
    if (clk_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (frame_bytes_due.size() == 0) begin
          flag_mismatch("item with none due, byte", out_tdata, 8'h00);
        end else begin
          want = frame_bytes_due.pop_front();
          if (out_tuser !== want.kind) flag_mismatch("kind", {7'd0, out_tuser}, {7'd0, want.kind});
          if (out_tdata !== want.val) flag_mismatch("byte", out_tdata, want.val);
          if (out_tlast !== want.last) flag_mismatch("last", {7'd0, out_tlast}, {7'd0, want.last});
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic feed(input logic op, input logic [7:0] rx);
    rx_feed.push_back('{op, rx});
    rx_sent++;
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_MAX_LENGTH) max_len_reg = val[5:0];
    else tmo_reg = val;
    cfg_valid <= 1'b0;
  endtask

  // Waits for every reply, then pushes filler bytes until the receiver is back in the hunt.
  task automatic settle_to_hunt();
    bit done;
    done = 1'b0;
    while (!done) begin
      do @(negedge clk); while (rx_taken != rx_sent || frame_bytes_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clk);
      if (hunt_phase == ST_SYNC1) done = 1'b1;
      else feed(OP_BYTE, 8'h00);
    end
  endtask

  task automatic maybe_ticks();
    int n;
    if ($urandom_range(0, 5) == 0) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 5);
      repeat (n) feed(OP_TICK, 8'($urandom));
    end
  endtask

  // A framed packet with random payload; a cut one stops partway through.
  task automatic add_packet(input bit whole);
    int         eff;
    int         keep;
    logic [7:0] len;
    logic [7:0] chk;
    logic [7:0] v;
    eff = (max_len_reg > DEPTH) ? DEPTH : max_len_reg;
    case ($urandom_range(0, 15))
      0:       len = 8'h00;
      1:       len = 8'(eff + $urandom_range(1, 255 - eff));
      2, 3:    len = 8'(eff);
      default: len = (eff == 0) ? 8'($urandom_range(1, 255)) :
                                  8'($urandom_range(1, (eff < 6) ? eff : 6));
    endcase
    feed(OP_BYTE, SYNC_BYTE);
    feed(OP_BYTE, SYNC_BYTE);
    maybe_ticks();
    feed(OP_BYTE, len);
    if (len != 8'h00 && len <= eff) begin
      keep = whole ? len + 1 : $urandom_range(0, len - 1);
      chk  = len;
      for (int k = 0; k < len && k < keep; k++) begin
        maybe_ticks();
        v = 8'($urandom);
        feed(OP_BYTE, v);
        chk = chk + v;
      end
      if (keep > len) begin
        maybe_ticks();
        chk = ~chk;
        if ($urandom_range(0, 5) == 0) chk = chk ^ 8'($urandom_range(1, 255));
        feed(OP_BYTE, chk);
      end
    end
  endtask

  task automatic queue_random(input int n);
    int start;
    start = rx_sent;
    while (rx_sent - start < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: add_packet(1'b1);
        7: add_packet(1'b0);
        8: feed(OP_BYTE, ($urandom_range(0, 2) == 0) ? SYNC_BYTE : 8'($urandom));
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            feed(OP_TICK, 8'($urandom));
          end else begin
            feed(OP_BYTE, SYNC_BYTE);
            feed(OP_BYTE, 8'($urandom_range(0, 254)));
          end
        end
      endcase
    end
  endtask

  initial begin
    logic [5:0]  len_cfg;
    logic [15:0] tmo_cfg;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    @(negedge clk);

    // Sync mismatch, zero length, a good one-byte packet, a bad checksum,
    // the largest length byte, and a tick while hunting.
    feed(OP_BYTE, SYNC_BYTE);
    feed(OP_BYTE, 8'h00);
    feed(OP_BYTE, SYNC_BYTE);
    feed(OP_BYTE, SYNC_BYTE);
    feed(OP_BYTE, 8'h00);
    feed(OP_BYTE, SYNC_BYTE);
    feed(OP_BYTE, SYNC_BYTE);
    feed(OP_BYTE, 8'h01);
    feed(OP_BYTE, 8'h00);
    feed(OP_BYTE, 8'hFE);
    feed(OP_BYTE, SYNC_BYTE);
    feed(OP_BYTE, SYNC_BYTE);
    feed(OP_BYTE, 8'h02);
    feed(OP_BYTE, 8'hFF);
    feed(OP_BYTE, 8'h80);
    feed(OP_BYTE, 8'h00);
    feed(OP_BYTE, SYNC_BYTE);
    feed(OP_BYTE, SYNC_BYTE);
    feed(OP_BYTE, 8'hFF);
    feed(OP_TICK, 8'hA5);
    settle_to_hunt();

    // A zero limit rejects any length, and a zero timeout fires on the first tick.
    write_reg(CFG_MAX_LENGTH, 16'd0);
    write_reg(CFG_TIMEOUT, 16'd0);
    @(negedge clk);
    feed(OP_BYTE, SYNC_BYTE);
    feed(OP_BYTE, SYNC_BYTE);
    feed(OP_BYTE, 8'h01);
    feed(OP_BYTE, SYNC_BYTE);
    feed(OP_BYTE, SYNC_BYTE);
    feed(OP_TICK, 8'h5A);
    settle_to_hunt();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin len_cfg = 6'd63; tmo_cfg = TICKS_MAX; end
        1: begin len_cfg = 6'd1;  tmo_cfg = 16'd3;     end
        2: begin len_cfg = 6'd32; tmo_cfg = 16'd12;    end
        3: begin len_cfg = 6'd17; tmo_cfg = 16'd1;     end
        4: begin
          len_cfg = 6'($urandom_range(1, 32));
          tmo_cfg = 16'($urandom_range(0, 30));
        end
        default: begin len_cfg = 6'd32; tmo_cfg = TIMEOUT_RESET; end
      endcase
      write_reg(CFG_MAX_LENGTH, {10'd0, len_cfg});
      write_reg(CFG_TIMEOUT, tmo_cfg);
      @(negedge clk);
      // The closing phase runs with both sides always ready.
      sender_gaps = (ph != 5) && ($urandom_range(0, 3) != 0);
      sink_stalls = (ph != 5) && ($urandom_range(0, 3) != 0);
      queue_random(45);
      settle_to_hunt();
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- serial_packet_frame_receiver.f -----
design/spfr_pkg.sv
design/spfr_ctrl.sv
design/spfr_dp.sv
design/serial_packet_frame_receiver.sv
tb/testbench.sv
